>>> src/lius_pkg.sv
`timescale 1ns / 1ps

package lius_pkg;

    // Width of the factor register as seen on the configuration channel.
    localparam int FACTOR_WIDTH = 6;

    localparam int MAX_FACTOR_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Depth of the queue between the front end and the interpolation engine.
    localparam int QUEUE_DEPTH = 2;

    // Factor zero counts as one, and anything above the ceiling saturates.
    function automatic logic [FACTOR_WIDTH-1:0] clamp_factor(
        input logic [FACTOR_WIDTH-1:0] raw,
        input logic [FACTOR_WIDTH-1:0] ceiling
    );
        logic [FACTOR_WIDTH-1:0] res;
        begin
            if (raw == '0)
                res = FACTOR_WIDTH'(1);
            else if (raw > ceiling)
                res = ceiling;
            else
                res = raw;
            return res;
        end
    endfunction

endpackage

>>> src/lius_ifs.sv
`timescale 1ns / 1ps

interface lius_smp_if #(
    parameter int SAMPLE_WIDTH = lius_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface lius_res_if #(
    parameter int SAMPLE_WIDTH = lius_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           run_last;
    logic                           vector_end;

    modport source (output valid, output value, output run_last, output vector_end,
                    input ready);
    modport sink   (input valid, input value, input run_last, input vector_end,
                    output ready);
endinterface

interface lius_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [lius_pkg::FACTOR_WIDTH-1:0]   factor;

    modport source (output valid, output factor, input ready);
    modport sink   (input valid, input factor, output ready);
endinterface

>>> src/lius_queue.sv
`timescale 1ns / 1ps

module lius_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lius_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

>>> src/lius_front.sv
`timescale 1ns / 1ps

module lius_front #(
    parameter int MAX_FACTOR   = lius_pkg::MAX_FACTOR_DEF,
    parameter int SAMPLE_WIDTH = lius_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_WIDTH  = 2 * SAMPLE_WIDTH + 2 + lius_pkg::FACTOR_WIDTH + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lius_smp_if.sink               in_ch,
    lius_cfg_if.sink               cfg,
    output logic                   push,
    output logic [ENTRY_WIDTH-1:0] push_data,
    input  logic                   full
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int FW = lius_pkg::FACTOR_WIDTH;

    logic [FW-1:0]        factor_reg;
    logic signed [SW-1:0] prev_reg;
    logic                 have_prev_reg;
    logic                 accept;
    logic signed [SW:0]   diff;
    logic                 neg;
    logic [SW:0]          mag;
    logic [FW-1:0]        fac_eff;

    assign in_ch.ready = !full;
    assign cfg.ready   = 1'b1;
    assign accept      = in_ch.valid && !full;

    // The difference needs one bit more than a sample; its magnitude fits unsigned.
    assign diff    = {in_ch.sample[SW-1], in_ch.sample} - {prev_reg[SW-1], prev_reg};
    assign neg     = diff[SW];
    assign mag     = neg ? (SW + 1)'(-diff) : (SW + 1)'(diff);
    assign fac_eff = lius_pkg::clamp_factor(factor_reg, FW'(MAX_FACTOR));

    // A sample opens an interval only when a previous sample of its vector exists.
    assign push      = accept && have_prev_reg;
    assign push_data = {prev_reg, mag, neg, fac_eff, in_ch.last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg    <= FW'(1);
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                factor_reg <= cfg.factor;
            if (accept)
            begin
                prev_reg      <= in_ch.sample;
                have_prev_reg <= !in_ch.last;
            end
        end
    end

endmodule

>>> src/lius_back.sv
`timescale 1ns / 1ps

module lius_back #(
    parameter int SAMPLE_WIDTH = lius_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_WIDTH  = 2 * SAMPLE_WIDTH + 2 + lius_pkg::FACTOR_WIDTH + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   empty,
    input  logic [ENTRY_WIDTH-1:0] pop_data,
    output logic                   pop,
    lius_res_if.source             out_ch
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int FW = lius_pkg::FACTOR_WIDTH;
    localparam int DW = SW + 1;
    localparam int CW = $clog2(DW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT,
        ST_FINAL
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    logic [DW-1:0]          quo_reg;
    logic [DW-1:0]          quo_next;
    logic [FW-1:0]          rem_reg;
    logic [FW-1:0]          rem_next;
    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic [DW-1:0]          acc_q_reg;
    logic [DW-1:0]          acc_q_next;
    logic [FW-1:0]          acc_r_reg;
    logic [FW-1:0]          acc_r_next;
    logic [FW-1:0]          k_reg;
    logic [FW-1:0]          k_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic signed [SW-1:0]   out_value_reg;
    logic signed [SW-1:0]   out_value_next;
    logic                   out_run_last_reg;
    logic                   out_run_last_next;
    logic                   out_vector_end_reg;
    logic                   out_vector_end_next;

    logic signed [SW-1:0] e_prev;
    logic [DW-1:0]        e_mag;
    logic                 e_neg;
    logic [FW-1:0]        e_fac;
    logic                 e_last;
    logic [FW:0]          trial;
    logic [FW:0]          r_sum;
    logic [DW-1:0]        off_mid;
    logic [DW-1:0]        off_end;
    logic [DW-1:0]        base;
    logic [DW-1:0]        val_mid;
    logic [DW-1:0]        val_end;
    logic                 can_load;

    assign {e_prev, e_mag, e_neg, e_fac, e_last} = entry_reg;

    // Restoring division step: shift in one dividend bit, subtract when it fits.
    assign trial = {rem_reg, quo_reg[DW-1]};

    // Running quotient and remainder of k*|diff| / factor.
    assign r_sum = {1'b0, acc_r_reg} + {1'b0, rem_reg};

    assign base    = {e_prev[SW-1], e_prev};
    assign off_mid = e_neg ? DW'(-acc_q_reg) : acc_q_reg;
    assign off_end = e_neg ? DW'(-e_mag) : e_mag;
    assign val_mid = base + off_mid;
    assign val_end = base + off_end;

    assign can_load = !out_valid_reg || out_ch.ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.value      = out_value_reg;
    assign out_ch.run_last   = out_run_last_reg;
    assign out_ch.vector_end = out_vector_end_reg;

    always_comb
    begin
        state_next          = state_reg;
        entry_next          = entry_reg;
        quo_next            = quo_reg;
        rem_next            = rem_reg;
        cnt_next            = cnt_reg;
        acc_q_next          = acc_q_reg;
        acc_r_next          = acc_r_reg;
        k_next              = k_reg;
        out_valid_next      = out_valid_reg;
        out_value_next      = out_value_reg;
        out_run_last_next   = out_run_last_reg;
        out_vector_end_next = out_vector_end_reg;
        pop                 = 1'b0;

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    entry_next = pop_data;
                    quo_next   = pop_data[ENTRY_WIDTH-SW-1 -: DW];
                    rem_next   = '0;
                    cnt_next   = CW'(DW - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, e_fac})
                begin
                    rem_next = FW'(trial - {1'b0, e_fac});
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[FW-1:0];
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    acc_q_next = '0;
                    acc_r_next = '0;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    out_valid_next      = 1'b1;
                    out_value_next      = val_mid[SW-1:0];
                    out_run_last_next   = (k_reg == e_fac - 1'b1) && !e_last;
                    out_vector_end_next = 1'b0;
                    if (r_sum >= {1'b0, e_fac})
                    begin
                        acc_r_next = FW'(r_sum - {1'b0, e_fac});
                        acc_q_next = acc_q_reg + quo_reg + 1'b1;
                    end
                    else
                    begin
                        acc_r_next = r_sum[FW-1:0];
                        acc_q_next = acc_q_reg + quo_reg;
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == e_fac - 1'b1)
                        state_next = e_last ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (can_load)
                begin
                    out_valid_next      = 1'b1;
                    out_value_next      = val_end[SW-1:0];
                    out_run_last_next   = 1'b1;
                    out_vector_end_next = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            out_value_reg      <= '0;
            out_run_last_reg   <= 1'b0;
            out_vector_end_reg <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            out_valid_reg      <= out_valid_next;
            out_value_reg      <= out_value_next;
            out_run_last_reg   <= out_run_last_next;
            out_vector_end_reg <= out_vector_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        acc_q_reg <= acc_q_next;
        acc_r_reg <= acc_r_next;
        k_reg     <= k_next;
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> k_reg < e_fac)
        else $error("interval counter ran past the factor");

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> (acc_r_reg < e_fac) && (rem_reg < e_fac))
        else $error("remainder not below the factor");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_vector_end_reg |-> out_run_last_reg)
        else $error("vector end without run end");

    a_final_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINAL |-> e_last)
        else $error("final point for an interval without last flag");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg == '0 |=> state_reg == ST_EMIT)
        else $error("division did not hand over to emission");

endmodule

>>> src/linear_interpolating_upsampler_top.sv
`timescale 1ns / 1ps

// Channel   Modport  Transaction carries
// in_ch     sink     sample, last
// out_ch    source   value, run_last, vector_end
// cfg       sink     factor
//
// The first sample of a vector is taken and gives no result.
// Every later sample leaves the queue, passes through the serial divider that forms
// |diff| / factor, then gives factor results, plus one more when it carries last.
// Two intervals can wait in the queue, so the input stalls only when it is full.
// The output register holds a result until it is taken; reset clears all control state.
module linear_interpolating_upsampler_top #(
    parameter int MAX_FACTOR   = lius_pkg::MAX_FACTOR_DEF,
    parameter int SAMPLE_WIDTH = lius_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lius_smp_if.sink    in_ch,
    lius_res_if.source  out_ch,
    lius_cfg_if.sink    cfg
);

    localparam int ENTRY_WIDTH = 2 * SAMPLE_WIDTH + 2 + lius_pkg::FACTOR_WIDTH + 1;

    logic                   push;
    logic [ENTRY_WIDTH-1:0] push_data;
    logic                   full;
    logic                   pop;
    logic [ENTRY_WIDTH-1:0] pop_data;
    logic                   empty;

    lius_front #(
        .MAX_FACTOR   (MAX_FACTOR),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_WIDTH  (ENTRY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    lius_queue #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (lius_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    lius_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_WIDTH  (ENTRY_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
